// ===== design/tvfs_pkg.sv =====
// Shared types and constants for the TSDF voxel fuse and sample block.
// Used by tvfs_div, tvfs_store, tvfs_interp and the top level.
package tvfs_pkg;

  // Input item kinds carried in tuser
  localparam logic [1:0] MODE_FUSE   = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_TRUNC = 1'b0;
  localparam logic [0:0] REG_MAXW  = 1'b1;

  // Q1.14 unity
  localparam logic [14:0] TSDF_ONE = 15'd16384;

  // Divider geometry
  localparam int DIV_W  = 32;
  localparam int DIV_DW = 16;
  localparam int DIV_SW = 5;

  // Division steps for each use
  localparam logic [DIV_SW-1:0] STEPS_TSDF  = 5'd14;
  localparam logic [DIV_SW-1:0] STEPS_AVG   = 5'd23;
  localparam logic [DIV_SW-1:0] STEPS_COLOR = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FUSE_RD,
    ST_FUSE_TDIV,
    ST_FUSE_NDIV,
    ST_SAMPLE,
    ST_DONE
  } tvfs_state_t;

  // Request to a bit-serial divider
  typedef struct packed {
    logic              start;
    logic [DIV_SW-1:0] steps;
    logic [DIV_DW-1:0] rem_init;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_DW-1:0] divisor;
  } tvfs_div_req_t;

  // Write enables of the voxel store
  typedef struct packed {
    logic we_weight;
    logic we_data;
  } tvfs_wen_t;

  // Control of the trilinear accumulator
  typedef struct packed {
    logic       start;
    logic       issue;
    logic [2:0] corner;
  } tvfs_smp_ctl_t;

endpackage

// ===== design/tvfs_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on tvfs_pkg for the request struct and widths.
module tvfs_div import tvfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  tvfs_div_req_t       req,
  output logic                busy,
  output logic [DIV_W-1:0]    quot
);

  logic [DIV_DW:0]    rem_r;
  logic [DIV_W-1:0]   q_r;
  logic [DIV_DW-1:0]  div_r;
  logic [DIV_SW-1:0]  cnt_r;
  logic               busy_r;
  logic [DIV_DW:0]    shifted;
  logic               ge;

  // one shift, compare and subtract step
  assign shifted = {rem_r[DIV_DW-1:0], q_r[DIV_W-1]};
  assign ge      = (shifted >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= (req.steps != '0);
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != DIV_SW'(1));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.rem_init};
      q_r   <= req.dividend;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (shifted - {1'b0, div_r}) : shifted;
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

// ===== design/tvfs_store.sv =====
// Voxel store: weight memory and tsdf/color memory, with registered read data.
// Depends on tvfs_pkg for the write-enable struct.
module tvfs_store import tvfs_pkg::*; #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_weight,
  output logic [47:0]   rd_data,
  input  tvfs_wen_t     wen,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_weight,
  input  logic [47:0]   wr_data
);

  logic [7:0]  weight_mem [DEPTH];
  logic [47:0] data_mem   [DEPTH];
  logic [7:0]  rd_weight_r;
  logic [47:0] rd_data_r;

  // weight memory
  always_ff @(posedge clk) begin
    if (wen.we_weight) begin
      weight_mem[wr_addr] <= wr_weight;
    end
    rd_weight_r <= weight_mem[rd_addr];
  end

  // tsdf in low 16 bits, RGBA above
  always_ff @(posedge clk) begin
    if (wen.we_data) begin
      data_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= data_mem[rd_addr];
  end

  assign rd_weight = rd_weight_r;
  assign rd_data   = rd_data_r;

endmodule

// ===== design/tvfs_interp.sv =====
// Trilinear accumulator: four-stage pipeline over the eight cell corners.
// Depends on tvfs_pkg; corner data comes from tvfs_store in the cycle after issue.
module tvfs_interp import tvfs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tvfs_smp_ctl_t      ctl,
  input  logic [7:0]         frac_x,
  input  logic [7:0]         frac_y,
  input  logic [7:0]         frac_z,
  input  logic [7:0]         rd_weight,
  input  logic signed [15:0] rd_tsdf,
  output logic               done,
  output logic               empty,
  output logic signed [15:0] value
);

  logic [8:0]         wx, wy, wz;
  logic               va_r, vb_r, vc_r;
  logic               last_a_r, last_b_r, last_c_r;
  logic [17:0]        wxy_r;
  logic [8:0]         wz_r;
  logic [26:0]        wxyz_full;
  logic [24:0]        wxyz_r;
  logic signed [15:0] tsdf_b_r;
  logic signed [41:0] prod_r;
  logic signed [43:0] acc_r;
  logic signed [43:0] acc_adj;
  logic               empty_r;
  logic               done_r;

  // corner weights: f for the upper corner, 256 - f for the lower one
  assign wx = ctl.corner[0] ? {1'b0, frac_x} : (9'd256 - {1'b0, frac_x});
  assign wy = ctl.corner[1] ? {1'b0, frac_y} : (9'd256 - {1'b0, frac_y});
  assign wz = ctl.corner[2] ? {1'b0, frac_z} : (9'd256 - {1'b0, frac_z});
  assign wxyz_full = wxy_r * wz_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      vc_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      va_r   <= ctl.issue;
      vb_r   <= va_r;
      vc_r   <= vb_r;
      done_r <= vc_r && last_c_r;
    end
  end

  // stages A to C: weight products, corner tsdf times weight
  always_ff @(posedge clk) begin
    wxy_r    <= wx * wy;
    wz_r     <= wz;
    last_a_r <= (ctl.corner == 3'd7);
    wxyz_r   <= wxyz_full[24:0];
    tsdf_b_r <= rd_tsdf;
    last_b_r <= last_a_r;
    prod_r   <= tsdf_b_r * $signed({1'b0, wxyz_r});
    last_c_r <= last_b_r;
  end

  // stage D: accumulate, and note any empty corner
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r   <= '0;
      empty_r <= 1'b0;
    end else begin
      if (vc_r) begin
        acc_r <= acc_r + {{2{prod_r[41]}}, prod_r};
      end
      if (va_r && (rd_weight == 8'd0)) begin
        empty_r <= 1'b1;
      end
    end
  end

  // divide by 2^24, truncating toward zero
  assign acc_adj = acc_r + (acc_r[43] ? 44'sd16777215 : 44'sd0);
  assign value   = acc_adj[39:24];
  assign empty   = empty_r;
  assign done    = done_r;

endmodule

// ===== design/tsdf_voxel_fuse_and_sample_top.sv =====
// Top level of the TSDF voxel fuse and sample block: control, fuse datapath.
// Depends on tvfs_pkg, tvfs_div, tvfs_store and tvfs_interp.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/tready    | tdata: item fields, tuser: mode
//  out_    | out | out_tvalid/tready   | tdata: distance and weight, tuser: valid
//  cfg_    | in  | cfg_valid/ready     | cfg_index, cfg_data
//
// One item at a time. Fuse runs the store read beside a 14-step division for
// the clamped tsdf, then a 23-step division for the running average (color
// averages run beside it), then the write back. Sample runs eight corner
// reads through a four-stage multiply-accumulate pipeline. Clear sweeps the
// weight memory, one voxel a cycle; the same sweep runs after reset, with
// in_tready low. A finished result waits in the output register while the
// next word is accepted; a new result stalls only if that register is full.
module tsdf_voxel_fuse_and_sample_top import tvfs_pkg::*; #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64,
  parameter int GRID_Z = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // voxel_x, voxel_y, voxel_z, frac_x, frac_y, frac_z, signed_distance,
  // color_red, color_green, color_blue, color_alpha, zero fill
  input  logic [95:0] in_tdata,
  // mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // distance_value, new_weight
  output logic [23:0] out_tdata,
  // value_valid
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [9:0] GX_L = 10'(GRID_X);
  localparam logic [9:0] GY_L = 10'(GRID_Y);
  localparam logic [9:0] GZ_L = 10'(GRID_Z);

  function automatic logic [AW-1:0] vox_addr(logic [9:0] x, logic [9:0] y, logic [9:0] z);
    return (AW'(z) * AW'(GRID_Y) + AW'(y)) * AW'(GRID_X) + AW'(x);
  endfunction

  tvfs_state_t state_r, state_nxt;

  // configuration
  logic [14:0] trunc_r;
  logic [7:0]  wmax_r;
  logic [14:0] trunc_eff;
  logic [7:0]  wmax_eff;

  // input word fields
  logic [1:0]  in_mode;
  logic [5:0]  in_x, in_y, in_z;
  logic [7:0]  in_fx, in_fy, in_fz;
  logic [15:0] in_sdf;
  logic [31:0] in_col;
  logic [15:0] in_mag;
  logic        in_clamp, in_colok, in_fuse_ok, in_smp_ok, in_fire;

  // latched item
  logic [5:0]  x_r, y_r, z_r;
  logic [7:0]  fx_r, fy_r, fz_r;
  logic [31:0] col_r;
  logic [AW-1:0] addr_r;
  logic        clamp_r, neg_r, colok_r, clr_report_r;

  // fuse datapath
  logic [7:0]         old_w_r;
  logic [31:0]        old_c_r;
  logic signed [24:0] prod_r;
  logic               nsign_r;
  logic [7:0]         rd_weight;
  logic [47:0]        rd_data;
  logic [15:0]        rd_tsdf_m;
  logic [31:0]        rd_col_m;
  logic [14:0]        tmag;
  logic signed [16:0] t_s;
  logic signed [24:0] num;
  logic [23:0]        nmag;
  logic [8:0]         w_inc;
  logic [7:0]         new_w;
  logic [15:0]        nv;
  logic [31:0]        new_col;
  logic [15:0]        cnum [4];

  // dividers
  tvfs_div_req_t      avg_req;
  tvfs_div_req_t      col_req [4];
  logic               avg_busy;
  logic [DIV_W-1:0]   avg_quot;
  logic [3:0]         col_busy;
  logic [DIV_W-1:0]   col_quot [4];

  // store ports
  logic [AW-1:0] mem_rd_addr, mem_wr_addr, clr_cnt_r;
  tvfs_wen_t     mem_wen;
  logic [7:0]    mem_wr_weight;
  logic [47:0]   mem_wr_data;

  // sampling
  tvfs_smp_ctl_t smp_ctl;
  logic [2:0]    corner_r;
  logic          issue_done_r;
  logic          smp_done, smp_empty;
  logic signed [15:0] smp_value;
  logic [9:0]    cx, cy, cz;

  // result holding and output register
  logic [15:0] res_dist_r;
  logic [7:0]  res_w_r;
  logic        res_v_r;
  logic [15:0] out_dist_r;
  logic [7:0]  out_w_r;
  logic        out_v_r;
  logic        out_valid_r;
  logic        slot_free;
  logic        fuse_end;

  // unpack the input word
  assign in_mode = in_tuser;
  assign in_x    = in_tdata[5:0];
  assign in_y    = in_tdata[11:6];
  assign in_z    = in_tdata[17:12];
  assign in_fx   = in_tdata[25:18];
  assign in_fy   = in_tdata[33:26];
  assign in_fz   = in_tdata[41:34];
  assign in_sdf  = in_tdata[57:42];
  assign in_col  = in_tdata[89:58];

  assign trunc_eff = (trunc_r == 15'd0) ? 15'd1 : trunc_r;
  assign wmax_eff  = (wmax_r == 8'd0) ? 8'd1 : wmax_r;

  // magnitude of the distance and its range tests
  assign in_mag    = in_sdf[15] ? (~in_sdf + 16'd1) : in_sdf;
  assign in_clamp  = (in_mag >= {1'b0, trunc_eff});
  // color is averaged when twice the magnitude stays within the truncation
  assign in_colok  = ({in_mag, 1'b0} <= {2'b0, trunc_eff});
  assign in_fuse_ok = ({4'd0, in_x} < GX_L) && ({4'd0, in_y} < GY_L) &&
                      ({4'd0, in_z} < GZ_L);
  assign in_smp_ok  = (({4'd0, in_x} + 10'd1) < GX_L) && (({4'd0, in_y} + 10'd1) < GY_L) &&
                      (({4'd0, in_z} + 10'd1) < GZ_L);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_tready;

  // old voxel contents, empty voxel reads as zero
  assign rd_tsdf_m = (rd_weight != 8'd0) ? rd_data[15:0] : 16'd0;
  assign rd_col_m  = (rd_weight != 8'd0) ? rd_data[47:16] : 32'd0;

  // clamped tsdf and the running-average numerator
  assign tmag  = clamp_r ? TSDF_ONE : {1'b0, avg_quot[13:0]};
  assign t_s   = neg_r ? -$signed({2'b0, tmag}) : $signed({2'b0, tmag});
  assign num   = prod_r + 25'(t_s);
  assign nmag  = num[24] ? 24'(-num) : num[23:0];
  assign w_inc = {1'b0, old_w_r} + 9'd1;
  assign new_w = (w_inc > {1'b0, wmax_eff}) ? wmax_eff : w_inc[7:0];
  assign nv    = nsign_r ? (~avg_quot[15:0] + 16'd1) : avg_quot[15:0];
  assign new_col = colok_r ? {col_quot[3][7:0], col_quot[2][7:0],
                              col_quot[1][7:0], col_quot[0][7:0]} : old_c_r;
  assign fuse_end = (state_r == ST_FUSE_NDIV) && !avg_busy && (col_busy == 4'd0);

  // corner coordinates
  assign cx = {4'd0, x_r} + {9'd0, corner_r[0]};
  assign cy = {4'd0, y_r} + {9'd0, corner_r[1]};
  assign cz = {4'd0, z_r} + {9'd0, corner_r[2]};

  // next state and store / divider control
  always_comb begin
    state_nxt     = state_r;
    mem_rd_addr   = vox_addr({4'd0, in_x}, {4'd0, in_y}, {4'd0, in_z});
    mem_wen       = '0;
    mem_wr_addr   = addr_r;
    mem_wr_weight = new_w;
    mem_wr_data   = {new_col, nv};
    avg_req       = '0;
    smp_ctl       = '0;
    smp_ctl.corner = corner_r;
    for (int c = 0; c < 4; c++) begin
      col_req[c] = '0;
    end
    case (state_r)
      ST_CLEAR: begin
        mem_wen.we_weight = 1'b1;
        mem_wr_addr       = clr_cnt_r;
        mem_wr_weight     = 8'd0;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = clr_report_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_FUSE: begin
              if (in_fuse_ok) begin
                avg_req.start    = 1'b1;
                avg_req.steps    = STEPS_TSDF;
                avg_req.rem_init = in_clamp ? 16'd0 : {1'b0, in_mag[14:0]};
                avg_req.dividend = '0;
                avg_req.divisor  = {1'b0, trunc_eff};
                state_nxt        = ST_FUSE_RD;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            MODE_SAMPLE: begin
              smp_ctl.start = 1'b1;
              state_nxt     = in_smp_ok ? ST_SAMPLE : ST_DONE;
            end
            MODE_CLEAR: state_nxt = ST_CLEAR;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FUSE_RD: state_nxt = ST_FUSE_TDIV;
      ST_FUSE_TDIV: begin
        if (!avg_busy) begin
          avg_req.start    = 1'b1;
          avg_req.steps    = STEPS_AVG;
          avg_req.rem_init = '0;
          avg_req.dividend = {nmag[22:0], 9'd0};
          avg_req.divisor  = {7'd0, w_inc};
          for (int c = 0; c < 4; c++) begin
            col_req[c].start    = 1'b1;
            col_req[c].steps    = STEPS_COLOR;
            col_req[c].rem_init = '0;
            col_req[c].dividend = {cnum[c], 16'd0};
            col_req[c].divisor  = {7'd0, w_inc};
          end
          state_nxt = ST_FUSE_NDIV;
        end
      end
      ST_FUSE_NDIV: begin
        if (fuse_end) begin
          mem_wen.we_weight = 1'b1;
          mem_wen.we_data   = 1'b1;
          state_nxt         = ST_DONE;
        end
      end
      ST_SAMPLE: begin
        mem_rd_addr   = vox_addr(cx, cy, cz);
        smp_ctl.issue = !issue_done_r;
        if (smp_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // color numerators: old * weight + observed
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cnum[c] = old_c_r[8*c +: 8] * old_w_r + {8'd0, col_r[8*c +: 8]};
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_r <= 15'd246;
      wmax_r  <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRUNC: trunc_r <= cfg_data;
        REG_MAXW:  wmax_r  <= cfg_data[7:0];
        default:   trunc_r <= trunc_r;
      endcase
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      corner_r     <= '0;
      issue_done_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (in_fire) begin
        clr_cnt_r    <= '0;
        clr_report_r <= 1'b1;
        corner_r     <= '0;
        issue_done_r <= 1'b0;
      end else if (smp_ctl.issue) begin
        corner_r     <= corner_r + 3'd1;
        issue_done_r <= (corner_r == 3'd7);
      end
    end
  end

  // item and fuse datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r     <= in_x;
      y_r     <= in_y;
      z_r     <= in_z;
      fx_r    <= in_fx;
      fy_r    <= in_fy;
      fz_r    <= in_fz;
      col_r   <= in_col;
      addr_r  <= mem_rd_addr;
      clamp_r <= in_clamp;
      neg_r   <= in_sdf[15];
      colok_r <= in_colok;
    end
    if (state_r == ST_FUSE_RD) begin
      old_w_r <= rd_weight;
      old_c_r <= rd_col_m;
      prod_r  <= $signed(rd_tsdf_m) * $signed({1'b0, rd_weight});
    end
    if (state_r == ST_FUSE_TDIV) begin
      nsign_r <= num[24];
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (in_fire || (state_r == ST_CLEAR)) begin
      res_dist_r <= '0;
      res_w_r    <= '0;
      res_v_r    <= 1'b0;
    end else if (fuse_end) begin
      res_dist_r <= nv;
      res_w_r    <= new_w;
      res_v_r    <= 1'b1;
    end else if ((state_r == ST_SAMPLE) && smp_done) begin
      res_dist_r <= smp_empty ? 16'd0 : smp_value;
      res_w_r    <= '0;
      res_v_r    <= !smp_empty;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && slot_free) begin
      out_dist_r <= res_dist_r;
      out_w_r    <= res_w_r;
      out_v_r    <= res_v_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_w_r, out_dist_r};
  assign out_tuser  = out_v_r;

  tvfs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .rd_addr   (mem_rd_addr),
    .rd_weight (rd_weight),
    .rd_data   (rd_data),
    .wen       (mem_wen),
    .wr_addr   (mem_wr_addr),
    .wr_weight (mem_wr_weight),
    .wr_data   (mem_wr_data)
  );

  tvfs_div u_avg_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (avg_req),
    .busy  (avg_busy),
    .quot  (avg_quot)
  );

  for (genvar c = 0; c < 4; c++) begin : g_col_div
    tvfs_div u_col_div (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (col_req[c]),
      .busy  (col_busy[c]),
      .quot  (col_quot[c])
    );
  end

  tvfs_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (smp_ctl),
    .frac_x    (fx_r),
    .frac_y    (fy_r),
    .frac_z    (fz_r),
    .rd_weight (rd_weight),
    .rd_tsdf   ($signed(rd_data[15:0])),
    .done      (smp_done),
    .empty     (smp_empty),
    .value     (smp_value)
  );

`ifndef SYNTHESIS
  // no word is taken while the weight sweep runs
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input accepted during weight sweep");

  // an invalid result carries a zero distance
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_v_r) |-> (out_dist_r == 16'd0))
    else $error("invalid result with nonzero distance");

  // fuse write back keeps the weight within the limit and nonzero
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wen.we_data) |-> ((mem_wr_weight != 8'd0) && (mem_wr_weight <= wmax_eff)))
    else $error("fused weight out of range");

  // the shared divider is never restarted mid-division
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    avg_req.start |-> !avg_busy)
    else $error("divider started while busy");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the TSDF voxel fuse and sample block: directed and random fuse,
// sample, clear and unused-mode words, scored against an in-line voxel predictor.
// Depends on tvfs_pkg and tsdf_voxel_fuse_and_sample_top.
`timescale 1ns / 100ps

module tb_top;
  import tvfs_pkg::*;

  localparam int GRID = 64;
  localparam int VOXELS = GRID * GRID * GRID;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] mode;
    logic [5:0] vx, vy, vz;
    logic [7:0] fx, fy, fz;
    logic signed [15:0] sd;
    logic [7:0] red, green, blue, alpha;
  } voxel_word_t;

  typedef struct {
    logic [15:0] distance;
    logic [7:0]  weight;
    logic        valid;
  } voxel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  // Predictor state: tsdf and weight per voxel (color is never observed)
  logic signed [15:0] tsdf_mem [VOXELS];
  logic [7:0]         weight_mem [VOXELS];
  logic [14:0]        trunc_reg;
  logic [7:0]         maxw_reg;

  voxel_result_t expected_results[$];
  int mismatches = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  tsdf_voxel_fuse_and_sample_top DUT (.*);

  always #5 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  // Result checker
  always @(posedge clk) begin
    voxel_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 0);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata[15:0] !== exp_r.distance)
          report_mismatch("distance_value", $signed(out_tdata[15:0]),
                          $signed(exp_r.distance));
        if (out_tdata[23:16] !== exp_r.weight)
          report_mismatch("new_weight", out_tdata[23:16], exp_r.weight);
        if (out_tuser[0] !== exp_r.valid)
          report_mismatch("value_valid", out_tuser[0], exp_r.valid);
      end
    end
  end

  function automatic int voxel_addr(int x, int y, int z);
    return (z * GRID + y) * GRID + x;
  endfunction

  // Expected result of one word, updating the voxel state
  function automatic voxel_result_t fuse_or_sample(voxel_word_t w);
    voxel_result_t r;
    int trunc, wmax, t, old, wt, nv, idx, dx, dy, dz;
    longint acc, cw;
    r = '{16'd0, 8'd0, 1'b0};
    trunc = (trunc_reg == 0) ? 1 : int'(trunc_reg);
    wmax = (maxw_reg == 0) ? 1 : int'(maxw_reg);
    case (w.mode)
      MODE_FUSE: begin
        idx = voxel_addr(w.vx, w.vy, w.vz);
        t = (int'(w.sd) * 16384) / trunc;
        if (t > 16384) t = 16384;
        if (t < -16384) t = -16384;
        wt = weight_mem[idx];
        old = (wt != 0) ? int'(tsdf_mem[idx]) : 0;
        nv = (old * wt + t) / (wt + 1);
        tsdf_mem[idx] = nv[15:0];
        wt = wt + 1;
        if (wt > wmax) wt = wmax;
        weight_mem[idx] = wt[7:0];
        r = '{nv[15:0], wt[7:0], 1'b1};
      end
      MODE_SAMPLE: begin
        if (w.vx < GRID - 1 && w.vy < GRID - 1 && w.vz < GRID - 1) begin
          acc = 0;
          r.valid = 1'b1;
          for (int c = 0; c < 8; c++) begin
            dx = c & 1;
            dy = (c >> 1) & 1;
            dz = (c >> 2) & 1;
            idx = voxel_addr(w.vx + dx, w.vy + dy, w.vz + dz);
            if (weight_mem[idx] == 0) r.valid = 1'b0;
            cw = (dx ? longint'(w.fx) : 256 - longint'(w.fx))
               * (dy ? longint'(w.fy) : 256 - longint'(w.fy))
               * (dz ? longint'(w.fz) : 256 - longint'(w.fz));
            acc += longint'(tsdf_mem[idx]) * cw;
          end
          acc = acc / 16777216;
          if (r.valid) r.distance = acc[15:0];
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < VOXELS; i++) weight_mem[i] = 8'd0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one word; in_tvalid stays high unless a gap follows
  task automatic send_word(input voxel_word_t w);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.mode;
    in_tdata <= {6'd0, w.alpha, w.blue, w.green, w.red, w.sd,
                 w.fz, w.fy, w.fx, w.vz, w.vy, w.vx};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(fuse_or_sample(w));
  endtask

  // Drain, let the block settle, then write both registers
  task automatic write_config(input logic [14:0] trunc, input logic [7:0] maxw);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TRUNC;
    cfg_data <= trunc;
    do @(posedge clk); while (!cfg_ready);
    trunc_reg = trunc;
    cfg_index <= REG_MAXW;
    cfg_data <= {7'd0, maxw};
    do @(posedge clk); while (!cfg_ready);
    maxw_reg = maxw;
    cfg_valid <= 1'b0;
  endtask

  function automatic voxel_word_t make_word(logic [1:0] mode, int x, int y, int z,
                                             int fx, int fy, int fz, int sd);
    voxel_word_t w;
    w.mode = mode;
    w.vx = x; w.vy = y; w.vz = z;
    w.fx = fx; w.fy = fy; w.fz = fz;
    w.sd = sd;
    w.red = $urandom; w.green = $urandom; w.blue = $urandom; w.alpha = $urandom;
    return w;
  endfunction

  // Directed: empty voxels, clamping, corners of the grid, clear, unused mode
  task automatic test_directed();
    voxel_word_t w;
    send_word(make_word(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(MODE_FUSE, 0, 0, 0, 0, 0, 0, 32767));
    send_word(make_word(MODE_FUSE, 0, 0, 0, 0, 0, 0, -32768));
    send_word(make_word(MODE_FUSE, 0, 0, 0, 0, 0, 0, 123));
    w = make_word(MODE_FUSE, 63, 63, 63, 255, 255, 255, -100);
    w.red = 8'hff; w.green = 8'hff; w.blue = 8'hff; w.alpha = 8'hff;
    send_word(w);
    w = make_word(MODE_FUSE, 63, 63, 63, 0, 0, 0, 0);
    w.red = 0; w.green = 0; w.blue = 0; w.alpha = 0;
    send_word(w);
    // fill the eight corners of cell (1,1,1)
    for (int c = 0; c < 8; c++)
      send_word(make_word(MODE_FUSE, 1 + (c & 1), 1 + ((c >> 1) & 1), 1 + (c >> 2),
                          0, 0, 0, $urandom_range(0, 500) - 250));
    send_word(make_word(MODE_SAMPLE, 1, 1, 1, 0, 0, 0, 0));
    send_word(make_word(MODE_SAMPLE, 1, 1, 1, 255, 255, 255, 0));
    send_word(make_word(MODE_SAMPLE, 1, 1, 1, 128, 37, 200, 0));
    send_word(make_word(MODE_SAMPLE, 63, 0, 0, 0, 0, 0, 0));
    send_word(make_word(MODE_SAMPLE, 62, 62, 62, 10, 10, 10, 0));
    send_word(make_word(MODE_UNUSED, 1, 1, 1, 0, 0, 0, 0));
    send_word(make_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(MODE_SAMPLE, 1, 1, 1, 5, 5, 5, 0));
    send_word(make_word(MODE_FUSE, 1, 1, 1, 0, 0, 0, 1));
  endtask

  // Random: mostly fuses and samples packed into one small region
  task automatic test_random(input int count, input int base);
    voxel_word_t w;
    int roll, span;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      span = (trunc_reg < 2) ? 4 : 2 * int'(trunc_reg);
      w = make_word(MODE_FUSE, base + $urandom_range(2), base + $urandom_range(2),
                    base + $urandom_range(2), $urandom, $urandom, $urandom,
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, span) - span / 2);
      if (roll < 35) begin
        w.mode = MODE_SAMPLE;
        w.vx = base + $urandom_range(1); w.vy = base + $urandom_range(1);
        w.vz = base + $urandom_range(1);
        if (roll < 3) begin
          w.fx = 0; w.fy = 255; w.fz = 0;
        end
      end else if (roll < 40) begin
        w.mode = $urandom_range(1);
        w.vx = $urandom; w.vy = $urandom; w.vz = $urandom;
      end else if (roll < 44) begin
        w.mode = MODE_UNUSED;
      end
      send_word(w);
    end
  endtask

  initial begin
    trunc_reg = 15'd246;
    maxw_reg = 8'd255;
    for (int i = 0; i < VOXELS; i++) begin
      weight_mem[i] = 8'd0;
      tsdf_mem[i] = 16'sd0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 34; rx_idle_pct = 80;
    test_directed();
    write_config(15'd32767, 8'd3);
    test_random(380, 0);

    tx_idle_pct = 80; rx_idle_pct = 34;
    write_config(15'd1, 8'd1);
    test_random(200, 61);
    write_config(15'd0, 8'd0);
    test_random(180, 30);

    tx_idle_pct = 0; rx_idle_pct = 0;
    write_config(15'd400, 8'd255);
    test_random(370, 10);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
